// ===== rtl/lsr_pkg.sv =====
`timescale 1ns / 1ps
// lsr_pkg: shared types, codes and constants of the line span rasterizer
package lsr_pkg;

    // default coordinate width of the endpoint fields
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int FIELD_BITS = 16;
    localparam int SCREEN_BITS = 12;
    localparam int COLOR_BITS = 16;
    localparam int CFG_IDX_BITS = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCR_COLS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCR_ROWS = 1'b1;

    // configuration reset values
    localparam logic [SCREEN_BITS-1:0] SCR_COLS_RST = 12'd320;
    localparam logic [SCREEN_BITS-1:0] SCR_ROWS_RST = 12'd480;

    // request function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_HORIZ = 2'd0,
        KIND_VERT = 2'd1,
        KIND_PIXEL = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // one clipped run
    typedef struct packed {
        kind_t kind;
        logic [SCREEN_BITS-1:0] x;
        logic [SCREEN_BITS-1:0] y;
        logic [SCREEN_BITS-1:0] len;
    } lsr_run_t;

endpackage

// ===== rtl/line_span_rasterizer.sv =====
`timescale 1ns / 1ps
// A request's result passes from the request register to the result register.
// Throughput: one request per cycle while in_stall is low; the walker does one error-term step per step request.
// in_stall is high only while the request register is full and a result waits under out_stall.
// Reset (rst_n, asynchronous, active low) empties both registers, ends any line
// and loads screen width 320 and screen height 480.
// line_span_rasterizer: top level with request, walker state and result registers
module line_span_rasterizer
    import lsr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SCREEN_BITS-1:0]  cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [FIELD_BITS-1:0]   start_x,
    input  logic [FIELD_BITS-1:0]   start_y,
    input  logic [FIELD_BITS-1:0]   end_x,
    input  logic [FIELD_BITS-1:0]   end_y,
    input  logic [COLOR_BITS-1:0]   color,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              kind,
    output logic [SCREEN_BITS-1:0]  run_x,
    output logic [SCREEN_BITS-1:0]  run_y,
    output logic [SCREEN_BITS-1:0]  run_length,
    output logic [COLOR_BITS-1:0]   run_color,
    output logic                    last
);

    // configuration
    logic [SCREEN_BITS-1:0] width_reg, height_reg;

    // request register
    logic                  in_vld_reg;
    logic                  func_reg;
    logic [FIELD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  in_take, advance;

    // walker state
    logic                         busy_reg;
    logic                         steep_reg;
    logic signed [COORD_BITS:0]   major_pos_reg, major_end_reg, minor_pos_reg;
    logic                         minor_neg_reg;
    logic signed [COORD_BITS+1:0] error_term_reg;
    logic signed [COORD_BITS:0]   delta_major_reg, delta_minor_reg, run_begin_reg;
    logic [COLOR_BITS-1:0]        line_color_reg;

    // result register
    logic                   out_vld_reg, out_vld_next;
    kind_t                  kind_reg;
    logic [SCREEN_BITS-1:0] run_x_reg, run_y_reg, run_length_reg;
    logic [COLOR_BITS-1:0]  run_color_reg;
    logic                   last_reg;

    // setup results
    lsr_run_t                     st_run;
    logic                         st_sloped, st_steep, st_minor_neg;
    logic signed [COORD_BITS:0]   st_major_pos, st_major_end, st_minor_pos;
    logic signed [COORD_BITS+1:0] st_error_term;
    logic signed [COORD_BITS:0]   st_delta_major, st_delta_minor;

    // walker results
    lsr_run_t                     wk_run;
    logic                         wk_emit, wk_fin;
    logic signed [COORD_BITS:0]   wk_major_pos, wk_minor_pos, wk_run_begin;
    logic signed [COORD_BITS+1:0] wk_error_term;

    logic     is_start, emit;
    lsr_run_t res_run;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= SCR_COLS_RST;
            height_reg <= SCR_ROWS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCR_COLS: width_reg <= cfg_data;
                CFG_SCR_ROWS: height_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // handshake: stall only while a result waits and the request register is full
    assign in_stall = in_vld_reg && out_vld_reg && out_stall;
    assign in_take = in_valid && !in_stall;
    assign advance = in_vld_reg && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
            color_reg <= color;
        end
    end

    lsr_start #(
        .COORD_BITS (COORD_BITS)
    ) u_start (
        .start_x       (sx_reg),
        .start_y       (sy_reg),
        .end_x         (ex_reg),
        .end_y         (ey_reg),
        .scr_cols      (width_reg),
        .scr_rows      (height_reg),
        .run           (st_run),
        .sloped        (st_sloped),
        .steep         (st_steep),
        .major_pos     (st_major_pos),
        .major_end     (st_major_end),
        .minor_pos     (st_minor_pos),
        .minor_neg     (st_minor_neg),
        .error_term    (st_error_term),
        .delta_major   (st_delta_major),
        .delta_minor   (st_delta_minor)
    );

    lsr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .steep           (steep_reg),
        .major_pos       (major_pos_reg),
        .major_end       (major_end_reg),
        .minor_pos       (minor_pos_reg),
        .minor_neg       (minor_neg_reg),
        .error_term      (error_term_reg),
        .delta_major     (delta_major_reg),
        .delta_minor     (delta_minor_reg),
        .run_begin       (run_begin_reg),
        .scr_cols        (width_reg),
        .scr_rows        (height_reg),
        .run             (wk_run),
        .emit            (wk_emit),
        .fin             (wk_fin),
        .major_pos_next  (wk_major_pos),
        .minor_pos_next  (wk_minor_pos),
        .error_term_next (wk_error_term),
        .run_begin_next  (wk_run_begin)
    );

    // result selection
    assign is_start = (func_reg == FUNC_START);
    assign emit = is_start ? !st_sloped : (busy_reg && wk_emit);
    assign res_run = is_start ? st_run : wk_run;

    // line active flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (is_start)
            begin
                busy_reg <= st_sloped;
            end
            else if (busy_reg && wk_fin)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // walker state load on setup, update on each step
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (is_start)
            begin
                line_color_reg <= color_reg;
                steep_reg <= st_steep;
                major_pos_reg <= st_major_pos;
                major_end_reg <= st_major_end;
                minor_pos_reg <= st_minor_pos;
                minor_neg_reg <= st_minor_neg;
                error_term_reg <= st_error_term;
                delta_major_reg <= st_delta_major;
                delta_minor_reg <= st_delta_minor;
                run_begin_reg <= st_major_pos;
            end
            else if (busy_reg)
            begin
                major_pos_reg <= wk_major_pos;
                minor_pos_reg <= wk_minor_pos;
                error_term_reg <= wk_error_term;
                run_begin_reg <= wk_run_begin;
            end
        end
    end

    // result register
    assign out_vld_next = advance ? emit : (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg <= res_run.kind;
            run_x_reg <= res_run.x;
            run_y_reg <= res_run.y;
            run_length_reg <= res_run.len;
            run_color_reg <= is_start ? color_reg : line_color_reg;
            last_reg <= is_start ? 1'b1 : wk_fin;
        end
    end

    assign out_valid = out_vld_reg;
    assign kind = kind_reg;
    assign run_x = run_x_reg;
    assign run_y = run_y_reg;
    assign run_length = run_length_reg;
    assign run_color = run_color_reg;
    assign last = last_reg;

`ifndef SYNTHESIS
    // nothing-drawn results carry zero coordinates and length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && kind_reg == KIND_NONE) |->
        (run_x_reg == '0 && run_y_reg == '0 && run_length_reg == '0))
        else $error("empty result with non-zero fields");

    // single pixels have length one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && kind_reg == KIND_PIXEL) |-> (run_length_reg == SCREEN_BITS'(1)))
        else $error("pixel result with length other than one");

    // runs are at least two pixels long
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (kind_reg == KIND_HORIZ || kind_reg == KIND_VERT)) |->
        (run_length_reg > SCREEN_BITS'(1)))
        else $error("run shorter than two pixels");

    // a step with no line active gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_start && !busy_reg) |=> !out_vld_reg)
        else $error("result from a step while idle");
`endif

endmodule

// ===== rtl/lsr_clip.sv =====
`timescale 1ns / 1ps
// lsr_clip: clips one horizontal or vertical run against the screen size
module lsr_clip
    import lsr_pkg::*;
#(
    parameter int CW = 18
)
(
    input  logic                   vert,
    input  logic signed [CW-1:0]   x,
    input  logic signed [CW-1:0]   y,
    input  logic signed [CW-1:0]   n,
    input  logic [SCREEN_BITS-1:0] scr_cols,
    input  logic [SCREEN_BITS-1:0] scr_rows,
    output lsr_run_t               run
);

    logic signed [CW-1:0] wd;
    logic signed [CW-1:0] ht;
    logic signed [CW-1:0] pos;
    logic signed [CW-1:0] lim;
    logic signed [CW-1:0] room;
    logic signed [CW-1:0] len;
    logic                 off;

    // screen limits on the run's axis
    assign wd = CW'($signed({1'b0, scr_cols}));
    assign ht = CW'($signed({1'b0, scr_rows}));
    assign pos = vert ? y : x;
    assign lim = vert ? ht : wd;
    assign room = lim - pos;

    // start point off screen or empty run
    assign off = (x < 0) || (y < 0) || (x >= wd) || (y >= ht) || (n < 1);

    // cut the run at the far edge
    assign len = (n > room) ? room : n;

    // pick the kind and fields
    always_comb
    begin
        if (off)
        begin
            run.kind = KIND_NONE;
            run.x = '0;
            run.y = '0;
            run.len = '0;
        end
        else
        begin
            run.x = x[SCREEN_BITS-1:0];
            run.y = y[SCREEN_BITS-1:0];
            if (len < 2)
            begin
                run.kind = KIND_PIXEL;
                run.len = SCREEN_BITS'(1);
            end
            else
            begin
                run.kind = vert ? KIND_VERT : KIND_HORIZ;
                run.len = len[SCREEN_BITS-1:0];
            end
        end
    end

endmodule

// ===== rtl/lsr_start.sv =====
`timescale 1ns / 1ps
// lsr_start: line setup, rejection, clamping and immediate straight lines
module lsr_start
    import lsr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic [FIELD_BITS-1:0]      start_x,
    input  logic [FIELD_BITS-1:0]      start_y,
    input  logic [FIELD_BITS-1:0]      end_x,
    input  logic [FIELD_BITS-1:0]      end_y,
    input  logic [SCREEN_BITS-1:0]     scr_cols,
    input  logic [SCREEN_BITS-1:0]     scr_rows,
    output lsr_run_t                   run,
    output logic                       sloped,
    output logic                       steep,
    output logic signed [COORD_BITS:0]   major_pos,
    output logic signed [COORD_BITS:0]   major_end,
    output logic signed [COORD_BITS:0]   minor_pos,
    output logic                       minor_neg,
    output logic signed [COORD_BITS+1:0] error_term,
    output logic signed [COORD_BITS:0]   delta_major,
    output logic signed [COORD_BITS:0]   delta_minor
);

    localparam int CW = (COORD_BITS + 2 > 13) ? COORD_BITS + 2 : 13;

    logic signed [CW-1:0] x0, y0, x1, y1;
    logic signed [CW-1:0] x0c, y0c, x1c, y1c;
    logic signed [CW-1:0] wd, ht;
    logic signed [CW-1:0] dx, dy, adx, ady;
    logic signed [CW-1:0] a0, b0, a1, b1;
    logic signed [CW-1:0] ma0, mb0, ma1, mb1;
    logic signed [CW-1:0] dmaj, dmin;
    logic signed [CW-1:0] cx, cy, cn;
    logic                 reject, horiz, vline, cvert;

    // endpoints as two's complement of the coordinate width
    assign x0 = CW'($signed(start_x[COORD_BITS-1:0]));
    assign y0 = CW'($signed(start_y[COORD_BITS-1:0]));
    assign x1 = CW'($signed(end_x[COORD_BITS-1:0]));
    assign y1 = CW'($signed(end_y[COORD_BITS-1:0]));
    assign wd = CW'($signed({1'b0, scr_cols}));
    assign ht = CW'($signed({1'b0, scr_rows}));

    // whole line off screen
    assign reject = ((y0 < 0) && (y1 < 0)) || ((y0 > ht) && (y1 > ht)) ||
                    ((x0 < 0) && (x1 < 0)) || ((x0 > wd) && (x1 > wd));

    // clamp negative coordinates
    assign x0c = (x0 < 0) ? '0 : x0;
    assign y0c = (y0 < 0) ? '0 : y0;
    assign x1c = (x1 < 0) ? '0 : x1;
    assign y1c = (y1 < 0) ? '0 : y1;

    assign dx = x1c - x0c;
    assign dy = y1c - y0c;
    assign adx = (dx < 0) ? -dx : dx;
    assign ady = (dy < 0) ? -dy : dy;
    assign horiz = (y0c == y1c);
    assign vline = (x0c == x1c);

    // immediate straight line or rejection
    always_comb
    begin
        cvert = 1'b0;
        cx = x0c;
        cy = y0c;
        cn = '0;
        if (!reject)
        begin
            if (horiz)
            begin
                cx = (x0c < x1c) ? x0c : x1c;
                cn = adx + CW'(1);
            end
            else if (vline)
            begin
                cvert = 1'b1;
                cy = (y0c < y1c) ? y0c : y1c;
                cn = ady + CW'(1);
            end
        end
    end

    lsr_clip #(
        .CW (CW)
    ) u_clip (
        .vert     (cvert),
        .x        (cx),
        .y        (cy),
        .n        (cn),
        .scr_cols (scr_cols),
        .scr_rows (scr_rows),
        .run      (run)
    );

    // sloped line setup: swap to the major axis, order along it
    assign sloped = !reject && !horiz && !vline;
    assign steep = (ady > adx);
    assign a0 = steep ? y0c : x0c;
    assign b0 = steep ? x0c : y0c;
    assign a1 = steep ? y1c : x1c;
    assign b1 = steep ? x1c : y1c;
    assign ma0 = (a0 > a1) ? a1 : a0;
    assign mb0 = (a0 > a1) ? b1 : b0;
    assign ma1 = (a0 > a1) ? a0 : a1;
    assign mb1 = (a0 > a1) ? b0 : b1;
    assign dmaj = ma1 - ma0;
    assign dmin = (mb1 > mb0) ? (mb1 - mb0) : (mb0 - mb1);

    assign major_pos = ma0[COORD_BITS:0];
    assign major_end = ma1[COORD_BITS:0];
    assign minor_pos = mb0[COORD_BITS:0];
    assign minor_neg = !(mb0 < mb1);
    assign delta_major = dmaj[COORD_BITS:0];
    assign delta_minor = dmin[COORD_BITS:0];
    assign error_term = {2'b00, dmaj[COORD_BITS:1]};

endmodule

// ===== rtl/lsr_walk.sv =====
`timescale 1ns / 1ps
// lsr_walk: one major-axis iteration of the run walker
module lsr_walk
    import lsr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         steep,
    input  logic signed [COORD_BITS:0]   major_pos,
    input  logic signed [COORD_BITS:0]   major_end,
    input  logic signed [COORD_BITS:0]   minor_pos,
    input  logic                         minor_neg,
    input  logic signed [COORD_BITS+1:0] error_term,
    input  logic signed [COORD_BITS:0]   delta_major,
    input  logic signed [COORD_BITS:0]   delta_minor,
    input  logic signed [COORD_BITS:0]   run_begin,
    input  logic [SCREEN_BITS-1:0]       scr_cols,
    input  logic [SCREEN_BITS-1:0]       scr_rows,
    output lsr_run_t                     run,
    output logic                         emit,
    output logic                         fin,
    output logic signed [COORD_BITS:0]   major_pos_next,
    output logic signed [COORD_BITS:0]   minor_pos_next,
    output logic signed [COORD_BITS+1:0] error_term_next,
    output logic signed [COORD_BITS:0]   run_begin_next
);

    localparam int CW = (COORD_BITS + 2 > 13) ? COORD_BITS + 2 : 13;

    logic signed [COORD_BITS+1:0] err_sub;
    logic signed [CW-1:0]         mp, rb, mn, n, cx, cy, cn;
    logic                         hit, draw;

    // error term update
    assign err_sub = error_term - (COORD_BITS+2)'(delta_minor);
    assign hit = (err_sub < 0);
    assign fin = (major_pos >= major_end);

    // run closed by a minor step, or the trailing run on the last position
    assign mp = CW'(major_pos);
    assign rb = CW'(run_begin);
    assign mn = CW'(minor_pos);
    assign n = mp - rb + CW'(1);
    assign draw = hit || (mp > rb);
    assign emit = hit || fin;
    assign cn = draw ? n : '0;
    assign cx = steep ? mn : rb;
    assign cy = steep ? rb : mn;

    lsr_clip #(
        .CW (CW)
    ) u_clip (
        .vert     (steep),
        .x        (cx),
        .y        (cy),
        .n        (cn),
        .scr_cols (scr_cols),
        .scr_rows (scr_rows),
        .run      (run)
    );

    // next walker state
    assign major_pos_next = major_pos + (COORD_BITS+1)'(1);
    assign run_begin_next = hit ? major_pos_next : run_begin;
    assign minor_pos_next = !hit ? minor_pos :
                            (minor_neg ? minor_pos - (COORD_BITS+1)'(1)
                                       : minor_pos + (COORD_BITS+1)'(1));
    assign error_term_next = hit ? err_sub + (COORD_BITS+2)'(delta_major) : err_sub;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the line span rasterizer with its own run predictor
module tb_top
    import lsr_pkg::*;
();

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASES = 8;
    localparam int PHASE_BUDGET = 180;

    // one pending request as the driver presents it
    typedef struct packed {
        logic        func;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        logic [15:0] rgb;
        bit          hold;
    } line_req_t;

    // one expected run
    typedef struct packed {
        lsr_run_t    run;
        logic [15:0] rgb;
        logic        last;
    } span_t;

    // block ports
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_SCR_COLS;
    logic [SCREEN_BITS-1:0]  cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    func = FUNC_START;
    logic [FIELD_BITS-1:0]   start_x = '0;
    logic [FIELD_BITS-1:0]   start_y = '0;
    logic [FIELD_BITS-1:0]   end_x = '0;
    logic [FIELD_BITS-1:0]   end_y = '0;
    logic [COLOR_BITS-1:0]   color = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              kind;
    logic [SCREEN_BITS-1:0]  run_x;
    logic [SCREEN_BITS-1:0]  run_y;
    logic [SCREEN_BITS-1:0]  run_length;
    logic [COLOR_BITS-1:0]   run_color;
    logic                    last;

    // predictor copy of the screen size and the line walker
    logic [11:0] scr_w = SCR_COLS_RST;
    logic [11:0] scr_h = SCR_ROWS_RST;
    bit          walking;
    bit          steep;
    bit          minor_down;
    int          cur_major;
    int          end_major;
    int          cur_minor;
    int          err_acc;
    int          span_major;
    int          span_minor;
    int          seg_start;
    logic [15:0] line_rgb = '0;

    line_req_t   pending[$];
    span_t       runs_due[$];
    line_req_t   next_req;
    span_t       want;

    int errors;
    int reqs_taken;
    int starts_taken;
    int runs_checked;
    int gap_pct;
    int stall_pct;
    int gap_left;
    int burst_left;
    int stall_left;
    int cycle_count;

    line_span_rasterizer u_top (.*);

    always #6 clk = ~clk;

    function automatic int mag(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic span_t make_span(kind_t k, int x, int y, int n, bit fin);
        span_t r;
        r.run.kind = k;
        r.run.x = 12'(x);
        r.run.y = 12'(y);
        r.run.len = 12'(n);
        r.rgb = line_rgb;
        r.last = fin;
        return r;
    endfunction

    // run along x or along y, clipped to the screen
    function automatic span_t clip_span(bit along_y, int x, int y, int n, bit fin);
        int w;
        int h;
        int a;
        int lim;
        w = scr_w;
        h = scr_h;
        a = along_y ? y : x;
        lim = along_y ? h : w;
        if (x < 0 || y < 0 || x >= w || y >= h || n < 1)
            return make_span(KIND_NONE, 0, 0, 0, fin);
        if (a + n - 1 >= lim)
            n = lim - a;
        if (n < 2)
            return make_span(KIND_PIXEL, x, y, 1, fin);
        return make_span(along_y ? KIND_VERT : KIND_HORIZ, x, y, n, fin);
    endfunction

    // run on the major axis at the current minor position
    function automatic span_t major_span(int s, int n, bit fin);
        if (steep)
            return clip_span(1'b1, cur_minor, s, n, fin);
        return clip_span(1'b0, s, cur_minor, n, fin);
    endfunction

    // work out the runs one taken request causes
    task automatic predict_request(input logic f, input logic [15:0] sx, input logic [15:0] sy,
                                   input logic [15:0] ex, input logic [15:0] ey,
                                   input logic [15:0] rgb);
        int x0;
        int y0;
        int x1;
        int y1;
        int w;
        int h;
        int t;
        bit fin;
        bit hit;
        if (f == FUNC_START)
        begin
            x0 = $signed(sx);
            y0 = $signed(sy);
            x1 = $signed(ex);
            y1 = $signed(ey);
            w = scr_w;
            h = scr_h;
            line_rgb = rgb;
            walking = 1'b0;
            if ((y0 < 0 && y1 < 0) || (y0 > h && y1 > h) ||
                (x0 < 0 && x1 < 0) || (x0 > w && x1 > w))
            begin
                runs_due.push_back(make_span(KIND_NONE, 0, 0, 0, 1'b1));
                return;
            end
            x0 = x0 < 0 ? 0 : x0;
            x1 = x1 < 0 ? 0 : x1;
            y0 = y0 < 0 ? 0 : y0;
            y1 = y1 < 0 ? 0 : y1;
            if (y0 == y1)
                runs_due.push_back(clip_span(1'b0, x0 < x1 ? x0 : x1, y0, mag(x1 - x0) + 1, 1'b1));
            else if (x0 == x1)
                runs_due.push_back(clip_span(1'b1, x0, y0 < y1 ? y0 : y1, mag(y1 - y0) + 1, 1'b1));
            else
            begin
                // sloped line: set up the walk, no run yet
                steep = mag(y1 - y0) > mag(x1 - x0);
                if (steep)
                begin
                    t = x0; x0 = y0; y0 = t;
                    t = x1; x1 = y1; y1 = t;
                end
                if (x0 > x1)
                begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                span_major = x1 - x0;
                span_minor = mag(y1 - y0);
                err_acc = span_major / 2;
                minor_down = !(y0 < y1);
                cur_major = x0;
                end_major = x1;
                cur_minor = y0;
                seg_start = x0;
                walking = 1'b1;
            end
        end
        else if (walking)
        begin
            // one major-axis iteration
            fin = cur_major >= end_major;
            hit = 1'b0;
            err_acc -= span_minor;
            if (err_acc < 0)
            begin
                runs_due.push_back(major_span(seg_start, cur_major - seg_start + 1, fin));
                seg_start = cur_major + 1;
                cur_minor += minor_down ? -1 : 1;
                err_acc += span_major;
                hit = 1'b1;
            end
            cur_major++;
            if (fin)
            begin
                walking = 1'b0;
                // trailing run, an empty result when only one pixel long
                if (!hit && cur_major > seg_start + 1)
                    runs_due.push_back(major_span(seg_start, cur_major - seg_start, 1'b1));
                else if (!hit)
                    runs_due.push_back(make_span(KIND_NONE, 0, 0, 0, 1'b1));
            end
        end
    endtask

    task automatic add_req(input logic f, input int sx, input int sy, input int ex, input int ey,
                           input int rgb, input bit hold);
        line_req_t r;
        r.func = f;
        r.sx = 16'(sx);
        r.sy = 16'(sy);
        r.ex = 16'(ex);
        r.ey = 16'(ey);
        r.rgb = 16'(rgb);
        r.hold = hold;
        pending.push_back(r);
    endtask

    // step requests carry random, unused endpoint fields
    task automatic add_steps(input int n);
        for (int i = 0; i < n; i++)
            add_req(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
    endtask

    // coordinate near either edge of a screen axis, or anywhere on it
    function automatic int near_edge(int size);
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 16)) - 8;
            1: v = size + int'($urandom_range(0, 16)) - 8;
            default: v = int'($urandom_range(0, size + 16)) - 8;
        endcase
        return v;
    endfunction

    // request driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                reqs_taken++;
                if (func == FUNC_START)
                    starts_taken++;
                predict_request(func, start_x, start_y, end_x, end_y, color);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0 && !(pending[0].hold && runs_due.size() > 0))
                begin
                    next_req = pending.pop_front();
                    in_valid <= 1'b1;
                    func <= next_req.func;
                    start_x <= next_req.sx;
                    start_y <= next_req.sy;
                    end_x <= next_req.ex;
                    end_y <= next_req.ey;
                    color <= next_req.rgb;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        if ($urandom_range(0, 99) < gap_pct)
                            gap_left = $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // run monitor and stall pattern of the receiving side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                runs_checked++;
                if (runs_due.size() == 0)
                begin
                    $error("unexpected run: kind %0d x %0d y %0d length %0d",
                           kind, run_x, run_y, run_length);
                    errors++;
                end
                else
                begin
                    want = runs_due.pop_front();
                    check_field("kind", want.run.kind, kind);
                    check_field("run_x", want.run.x, run_x);
                    check_field("run_y", want.run.y, run_y);
                    check_field("run_length", want.run.len, run_length);
                    check_field("run_color", want.rgb, run_color);
                    check_field("last", want.last, last);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d runs outstanding", cycle_count,
                     runs_due.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // stimulus: directed lines, then random lines over several screen sizes
    initial
    begin
        int w_list[PHASES];
        int h_list[PHASES];
        int gap_list[PHASES];
        int stall_list[PHASES];
        int made;
        int mode;
        int reach;
        int nsteps;
        int x0;
        int y0;
        int x1;
        int y1;
        int cx0;
        int cy0;
        int cx1;
        int cy1;
        w_list = '{320, 4095, 1, 1, 4095, 0, 0, 320};
        h_list = '{480, 4095, 1, 4095, 1, 0, 0, 480};
        gap_list = '{30, 0, 70, 10, 50, 0, 40, 20};
        stall_list = '{30, 0, 10, 70, 50, 40, 0, 20};
        w_list[5] = $urandom_range(16, 64);
        h_list[5] = $urandom_range(16, 64);
        w_list[6] = $urandom_range(1, 4095);
        h_list[6] = $urandom_range(1, 4095);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            // new screen size, written while the block is idle
            if (p > 0)
            begin
                @(posedge clk);
                cfg_write <= 1'b1;
                cfg_index <= CFG_SCR_COLS;
                cfg_data <= 12'(w_list[p]);
                @(posedge clk);
                cfg_index <= CFG_SCR_ROWS;
                cfg_data <= 12'(h_list[p]);
                @(posedge clk);
                cfg_write <= 1'b0;
                scr_w = 12'(w_list[p]);
                scr_h = 12'(h_list[p]);
            end
            @(negedge clk);
            gap_pct = gap_list[p];
            stall_pct = stall_list[p];
            if (p == 0)
            begin
                add_req(FUNC_START, 5, 5, 5, 5, 16'h001F, 1'b0);             // single point
                add_req(FUNC_START, 10, 20, 3, 20, 16'hF800, 1'b0);          // reversed horizontal
                add_req(FUNC_START, 7, 400, 7, 500, 16'h07E0, 1'b0);         // past the bottom
                add_req(FUNC_START, -32768, -5, -1, -9, 16'h0000, 1'b0);     // wholly left
                add_req(FUNC_START, 32767, 32767, 400, -32768, 16'hFFFF, 1'b0); // wholly right
                add_req(FUNC_START, -100, 10, 50, 10, 16'h1234, 1'b0);       // clamped to zero
                add_req(FUNC_START, 320, 10, 320, 10, 16'h4321, 1'b0);       // clipped away
                add_req(FUNC_START, 319, 5, 400, 5, 16'hA5A5, 1'b0);         // clipped to a pixel
                add_steps(1);                                                // step with no line
                add_req(FUNC_START, 0, 0, 2, 1, 16'h5A5A, 1'b0);             // lone trailing pixel
                add_steps(3);
                add_req(FUNC_START, 10, 10, 11, 13, 16'hFFFF, 1'b1);         // steep, after drain
                add_steps(4);
                add_req(FUNC_START, 20, 10, 22, 9, 16'h8001, 1'b0);          // minor axis falling
                add_steps(3);
                add_req(FUNC_START, 40, 40, 41, 44, 16'h7FFE, 1'b0);         // abandoned mid-walk
                add_steps(1);
                add_req(FUNC_START, -5, -3, 6, -20, 16'h0F0F, 1'b0);         // wholly above
            end
            // random lines, mostly walked to the end
            made = 0;
            while (made < PHASE_BUDGET)
            begin
                mode = $urandom_range(0, 15);
                reach = ($urandom_range(0, 7) == 0) ? 60 : 12;
                x0 = near_edge(w_list[p]);
                y0 = near_edge(h_list[p]);
                x1 = x0 + int'($urandom_range(0, 2 * reach)) - reach;
                y1 = y0 + int'($urandom_range(0, 2 * reach)) - reach;
                cx0 = x0 < 0 ? 0 : x0;
                cy0 = y0 < 0 ? 0 : y0;
                cx1 = x1 < 0 ? 0 : x1;
                cy1 = y1 < 0 ? 0 : y1;
                if ((x0 > w_list[p] && x1 > w_list[p]) || (y0 > h_list[p] && y1 > h_list[p]) ||
                    cx0 == cx1 || cy0 == cy1)
                    nsteps = 0;
                else if (mag(cx1 - cx0) > mag(cy1 - cy0))
                    nsteps = mag(cx1 - cx0) + 1;
                else
                    nsteps = mag(cy1 - cy0) + 1;
                if (mode == 0)
                begin
                    // noise: endpoints anywhere in the field range, a few steps at most
                    x0 = $urandom_range(0, 65535);
                    y0 = $urandom_range(0, 65535);
                    x1 = $urandom_range(0, 65535);
                    y1 = $urandom_range(0, 65535);
                    nsteps = $urandom_range(0, 3);
                end
                else if (mode == 1)
                    nsteps = $urandom_range(0, nsteps);     // cut short by the next start
                add_req(FUNC_START, x0, y0, x1, y1, $urandom_range(0, 65535),
                        $urandom_range(0, 29) == 0);
                add_steps(nsteps);
                made += nsteps + 1;
                if ($urandom_range(0, 7) == 0)
                    add_steps($urandom_range(1, 2));
            end
            // park the walker before the next screen change
            add_req(FUNC_START, -1, -1, -1, -1, $urandom_range(0, 65535), 1'b0);
            while (pending.size() > 0 || in_valid || runs_due.size() > 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
        end
        if (runs_due.size() > 0)
        begin
            $error("%0d expected runs never arrived", runs_due.size());
            errors++;
        end
        $display("covered %0d requests (%0d line starts) and %0d checked runs",
                 reqs_taken, starts_taken, runs_checked);
        $display("over %0d screen sizes, with and without idling on either side", PHASES);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lsr_pkg.sv
rtl/lsr_clip.sv
rtl/lsr_start.sv
rtl/lsr_walk.sv
rtl/line_span_rasterizer.sv
tb/tb_top.sv
